/* rtl/core/als_pkg.sv */
`default_nettype none
package als_pkg;

  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int RAD_W     = 48;
  localparam int AREA_W    = 32;
  localparam int CH_W      = 16;

  localparam int DIR_W  = 18;
  localparam int DIST_W = 22;
  localparam int PDF_W  = 32;

  localparam int DIR_SHIFT  = 23;
  localparam int DIST_SHIFT = 6;
  localparam int DIST_ROUND = 32;
  localparam int PDF_SHIFT  = 4;

  localparam logic [DIR_W-1:0]  DIR_ONE  = 18'd65536;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [PDF_W-1:0]  PDF_MAX  = '1;

  // result packing
  localparam int OUT_DX_LSB   = 0;
  localparam int OUT_DY_LSB   = OUT_DX_LSB + DIR_W;
  localparam int OUT_DZ_LSB   = OUT_DY_LSB + DIR_W;
  localparam int OUT_DIST_LSB = OUT_DZ_LSB + DIR_W;
  localparam int OUT_PDF_LSB  = OUT_DIST_LSB + DIST_W;
  localparam int OUT_RED_LSB  = OUT_PDF_LSB + PDF_W;
  localparam int OUT_GRN_LSB  = OUT_RED_LSB + CH_W;
  localparam int OUT_BLU_LSB  = OUT_GRN_LSB + CH_W;
  localparam int OUT_FIELDS_W = OUT_BLU_LSB + CH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;
  localparam int TU_FACING    = 0;
  localparam int TU_DEGEN     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS  = 3'd0,
    CFG_NRM  = 3'd1,
    CFG_EX   = 3'd2,
    CFG_EY   = 3'd3,
    CFG_RAD  = 3'd4,
    CFG_AREA = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] pos;
    logic [CFG_W-1:0] nrm;
    logic [CFG_W-1:0] ex;
    logic [CFG_W-1:0] ey;
  } geom_t;

endpackage
`default_nettype wire

/* rtl/core/als_front.sv */
`default_nettype none
module als_front import als_pkg::*; #(
  parameter int CB = 21,
  parameter int SB = 16,
  localparam int PW  = SB + 1 + CB,
  localparam int DW  = CB + 3,
  localparam int SQW = 2 * DW + 2,
  localparam int AW  = DW + CB + 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ce,
  input  wire logic                  in_vld,
  input  wire logic signed [CB-1:0]  pt_x,
  input  wire logic signed [CB-1:0]  pt_y,
  input  wire logic signed [CB-1:0]  pt_z,
  input  wire logic [SB-1:0]         smp_u,
  input  wire logic [SB-1:0]         smp_v,
  input  wire geom_t                 geom,
  output logic                       vld,
  output logic [SQW-1:0]             sq,
  output logic [AW-1:0]              absdot,
  output logic                       neg,
  output logic [2:0][DW-1:0]         mag,
  output logic [2:0]                 dneg
);

  localparam logic signed [SB:0]   HALF_S = (SB+1)'(1) << (SB - 1);
  localparam logic signed [PW:0]   HALF_W = (PW+1)'(1) << (SB - 1);

  logic [3*CB-1:0] pos_e, nrm_e, ex_e, ey_e;
  logic signed [CB-1:0] pos_c [3];
  logic signed [CB-1:0] nrm_c [3];
  logic signed [CB-1:0] ex_c  [3];
  logic signed [CB-1:0] ey_c  [3];
  logic signed [CB-1:0] pt_c  [3];
  logic signed [SB:0]   su, sv;

  logic signed [PW-1:0] pa_nxt [3];
  logic signed [PW-1:0] pb_nxt [3];
  logic signed [PW-1:0] pa_r   [3];
  logic signed [PW-1:0] pb_r   [3];
  logic signed [CB-1:0] p_r    [3];
  logic                 v1_r;

  logic signed [PW:0]   s_sum  [3];
  logic signed [PW:0]   s_rnd  [3];
  logic signed [CB+1:0] off    [3];
  logic signed [DW-1:0] d_nxt  [3];
  logic signed [DW-1:0] d_r    [3];
  logic                 v2_r;

  logic [DW-1:0]           m_nxt   [3];
  logic [2*DW-1:0]         sqt_nxt [3];
  logic signed [DW+CB-1:0] dt_nxt  [3];
  logic [DW-1:0]           m3_r    [3];
  logic [2*DW-1:0]         sqt_r   [3];
  logic signed [DW+CB-1:0] dt_r    [3];
  logic [2:0]              dn3_r;
  logic                    v3_r;

  logic signed [AW-1:0] dot_nxt;
  logic [SQW-1:0]       sq_nxt;
  logic [SQW-1:0]       sq_r;
  logic [AW-1:0]        ad_r;
  logic                 neg_r;
  logic [2:0][DW-1:0]   m4_r;
  logic [2:0]           dn4_r;
  logic                 v4_r;

  assign pos_e = (3*CB)'(geom.pos);
  assign nrm_e = (3*CB)'(geom.nrm);
  assign ex_e  = (3*CB)'(geom.ex);
  assign ey_e  = (3*CB)'(geom.ey);
  assign pt_c[0] = pt_x;
  assign pt_c[1] = pt_y;
  assign pt_c[2] = pt_z;
  assign su = $signed({1'b0, smp_u}) - HALF_S;
  assign sv = $signed({1'b0, smp_v}) - HALF_S;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_c[k] = $signed(pos_e[k*CB +: CB]);
      nrm_c[k] = $signed(nrm_e[k*CB +: CB]);
      ex_c[k]  = $signed(ex_e[k*CB +: CB]);
      ey_c[k]  = $signed(ey_e[k*CB +: CB]);
      pa_nxt[k] = su * ex_c[k];
      pb_nxt[k] = sv * ey_c[k];
      s_sum[k] = (PW+1)'(pa_r[k]) + (PW+1)'(pb_r[k]);
      s_rnd[k] = s_sum[k] + HALF_W;
      off[k]   = (CB+2)'(s_rnd[k] >>> SB);
      d_nxt[k] = DW'(pos_c[k]) + DW'(off[k]) - DW'(p_r[k]);
      m_nxt[k]   = d_r[k][DW-1] ? DW'(-d_r[k]) : DW'(d_r[k]);
      sqt_nxt[k] = m_nxt[k] * m_nxt[k];
      dt_nxt[k]  = d_r[k] * nrm_c[k];
    end
    sq_nxt  = SQW'(sqt_r[0]) + SQW'(sqt_r[1]) + SQW'(sqt_r[2]);
    dot_nxt = AW'(dt_r[0]) + AW'(dt_r[1]) + AW'(dt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k]  <= pa_nxt[k];
        pb_r[k]  <= pb_nxt[k];
        p_r[k]   <= pt_c[k];
        d_r[k]   <= d_nxt[k];
        m3_r[k]  <= m_nxt[k];
        sqt_r[k] <= sqt_nxt[k];
        dt_r[k]  <= dt_nxt[k];
        dn3_r[k] <= d_r[k][DW-1];
        m4_r[k]  <= m3_r[k];
      end
      dn4_r <= dn3_r;
      sq_r  <= sq_nxt;
      neg_r <= dot_nxt[AW-1];
      ad_r  <= dot_nxt[AW-1] ? AW'(-dot_nxt) : AW'(dot_nxt);
    end
  end

  assign vld    = v4_r;
  assign sq     = sq_r;
  assign absdot = ad_r;
  assign neg    = neg_r;
  assign mag    = m4_r;
  assign dneg   = dn4_r;

endmodule
`default_nettype wire

/* rtl/core/als_sqrt.sv */
`default_nettype none
module als_sqrt import als_pkg::*; #(
  parameter int XW  = 62,
  parameter int PLW = 8,
  localparam int RW = XW / 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ce,
  input  wire logic           in_vld,
  input  wire logic [XW-1:0]  x,
  input  wire logic [PLW-1:0] pay_in,
  output logic                vld,
  output logic [RW-1:0]       root,
  output logic [PLW-1:0]      pay_out
);

  logic [XW-1:0]  rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [PLW-1:0] pay_r  [RW];
  logic           vld_r  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_st
    localparam int I = RW - 1 - j;
    logic [XW-1:0]  rem_in;
    logic [RW-1:0]  root_in;
    logic [PLW-1:0] pay_i;
    logic           vld_i;
    logic [XW:0]    trial;
    logic           take;
    logic [XW-1:0]  rem_nxt;
    logic [RW-1:0]  root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
      assign pay_i   = pay_in;
      assign vld_i   = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign pay_i   = pay_r[j-1];
      assign vld_i   = vld_r[j-1];
    end

    assign trial    = ((XW+1)'(root_in) << (I + 1)) + ((XW+1)'(1) << (2 * I));
    assign take     = {1'b0, rem_in} >= trial;
    assign rem_nxt  = take ? rem_in - trial[XW-1:0] : rem_in;
    assign root_nxt = take ? (root_in | (RW'(1) << I)) : root_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (ce) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        pay_r[j]  <= pay_i;
      end
    end
  end

  assign vld     = vld_r[RW-1];
  assign root    = root_r[RW-1];
  assign pay_out = pay_r[RW-1];

endmodule
`default_nettype wire

/* rtl/core/als_div.sv */
`default_nettype none
module als_div import als_pkg::*; #(
  parameter int NW  = 48,
  parameter int DNW = 32,
  parameter int QW  = 32,
  parameter int PLW = 1,
  localparam int CW = (NW > DNW + QW) ? NW + 1 : DNW + QW + 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ce,
  input  wire logic           in_vld,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DNW-1:0] den,
  input  wire logic [PLW-1:0] pay_in,
  output logic                vld,
  output logic [QW-1:0]       quo,
  output logic [PLW-1:0]      pay_out
);

  logic [NW-1:0]  rem_r [QW];
  logic [DNW-1:0] den_r [QW];
  logic [QW-1:0]  quo_r [QW];
  logic [PLW-1:0] pay_r [QW];
  logic           vld_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_st
    localparam int I = QW - 1 - j;
    logic [NW-1:0]  rem_in;
    logic [DNW-1:0] den_in;
    logic [QW-1:0]  quo_in;
    logic [PLW-1:0] pay_i;
    logic           vld_i;
    logic [CW-1:0]  shifted;
    logic           take;
    logic [NW-1:0]  rem_nxt;
    logic [QW-1:0]  quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign pay_i  = pay_in;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
      assign pay_i  = pay_r[j-1];
      assign vld_i  = vld_r[j-1];
    end

    assign shifted = CW'(den_in) << I;
    assign take    = CW'(rem_in) >= shifted;
    assign rem_nxt = take ? rem_in - shifted[NW-1:0] : rem_in;
    assign quo_nxt = take ? (quo_in | (QW'(1) << I)) : quo_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (ce) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_in;
        quo_r[j] <= quo_nxt;
        pay_r[j] <= pay_i;
      end
    end
  end

  assign vld     = vld_r[QW-1];
  assign quo     = quo_r[QW-1];
  assign pay_out = pay_r[QW-1];

endmodule
`default_nettype wire

/* rtl/core/area_light_sample.sv */
// channel   dir  tvalid/tready  tdata / tuser
// in_       in   in_tvalid      tdata: point_x,point_y,point_z,sample_u,sample_v
// out_      out  out_tvalid     tdata: dir_x..z,light_distance,sample_pdf,rgb; tuser
// cfg_      in   cfg_wr_en      cfg_index, cfg_wdata (no handshake)
//
// One transaction per cycle in and out while in_tready is high. The pipeline has four front
// stages, RW square-root stages (RW = COORD_BITS + 10, one root bit each), three multiply
// stages and 32 divider stages (one quotient bit each), and one output stage.
// Reset (synchronous) clears all valid bits and the light registers.
// The output register plus a one-entry skid take a stalled result; in_tready drops only
// while the skid is full, and then the whole pipeline holds.
`default_nettype none
module area_light_sample import als_pkg::*; #(
  parameter int COORD_BITS  = 21,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_TDATA_W = ((3 * COORD_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // point_x, point_y, point_z, sample_u, sample_v
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // dir_x, dir_y, dir_z, light_distance, sample_pdf, out_red, out_green, out_blue
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  // facing, degenerate
  output logic [OUT_TUSER_W-1:0]       out_tuser,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int SB   = SAMPLE_BITS;
  localparam int DW   = CB + 3;
  localparam int SQW  = 2 * DW + 2;
  localparam int AW   = DW + CB + 2;
  localparam int XW   = SQW + 12;
  localparam int RW   = XW / 2;
  localparam int SL   = SQW / 2;
  localparam int SH   = SQW - SL;
  localparam int AL   = AW / 2;
  localparam int AH   = AW - AL;
  localparam int NUMW = SQW + RW + PDF_SHIFT;
  localparam int DENW = AREA_W + AW;
  localparam int SATW = (NUMW > DENW + PDF_W) ? NUMW + 1 : DENW + PDF_W + 1;
  localparam int NDW  = DW + DIR_SHIFT + 1;
  localparam int DDW  = RW + 1;
  localparam int PLS  = SQW + AW + 1 + 3 * DW + 3;
  localparam int PLP  = 4 + DIST_W;
  localparam int RESW = OUT_TDATA_W + OUT_TUSER_W;

  logic [CFG_W-1:0]  pos_r, nrm_r, ex_r, ey_r;
  logic [RAD_W-1:0]  rad_r;
  logic [AREA_W-1:0] area_r;
  geom_t             geom;

  logic ce;

  logic               f_vld;
  logic [SQW-1:0]     f_sq;
  logic [AW-1:0]      f_ad;
  logic               f_neg;
  logic [2:0][DW-1:0] f_mag;
  logic [2:0]         f_dneg;

  logic               s_vld;
  logic [RW-1:0]      s_root;
  logic [PLS-1:0]     s_pay;
  logic [SQW-1:0]     s_sq;
  logic [AW-1:0]      s_ad;
  logic               s_neg;
  logic [2:0][DW-1:0] s_mag;
  logic [2:0]         s_dneg;

  logic [RW:0]        dsum;
  logic [RW:0]        dshr;
  logic [DIST_W-1:0]  dist_nxt;

  logic                m1_vld_r, m2_vld_r, m3_vld_r;
  logic [SH+RW-1:0]    ph_r;
  logic [SL+RW-1:0]    pl_r;
  logic [AREA_W+AH-1:0] ah_r;
  logic [AREA_W+AL-1:0] al_r;
  logic [2:0][NDW-1:0] nd1_r, nd2_r, nd3_r;
  logic [DDW-1:0]      dd1_r, dd2_r, dd3_r;
  logic [2:0]          dn1_r, dn2_r, dn3_r;
  logic                zero1_r, zero2_r, zero3_r;
  logic                cosz1_r, cosz2_r, cosz3_r;
  logic                neg1_r, neg2_r, neg3_r;
  logic [DIST_W-1:0]   dist1_r, dist2_r, dist3_r;
  logic [NUMW-1:0]     num2_r, num3_r;
  logic [DENW-1:0]     den2_r, den3_r;
  logic                sat3_r;

  logic               p_vld;
  logic [PDF_W-1:0]   p_quo;
  logic [PLP-1:0]     p_pay;
  logic               p_zero, p_cosz, p_neg, p_sat;
  logic [DIST_W-1:0]  p_dist;
  logic [2:0]         q_vld;
  logic [PDF_W-1:0]   q_quo [3];
  logic [2:0]         q_neg;

  logic               push;
  logic               area0;
  logic               facing;
  logic               degen;
  logic [DIR_W-1:0]   dmag [3];
  logic [DIR_W-1:0]   dval [3];
  logic [PDF_W-1:0]   pdf_val;
  logic [DIST_W-1:0]  dist_val;
  logic [RAD_W-1:0]   rad_val;
  logic [RESW-1:0]    res_nxt;
  logic [RESW-1:0]    out_data_r, skid_data_r;
  logic               out_vld_r, skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      nrm_r  <= '0;
      ex_r   <= '0;
      ey_r   <= '0;
      rad_r  <= '0;
      area_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POS:  pos_r  <= cfg_wdata;
        CFG_NRM:  nrm_r  <= cfg_wdata;
        CFG_EX:   ex_r   <= cfg_wdata;
        CFG_EY:   ey_r   <= cfg_wdata;
        CFG_RAD:  rad_r  <= cfg_wdata[RAD_W-1:0];
        CFG_AREA: area_r <= cfg_wdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom = '{pos: pos_r, nrm: nrm_r, ex: ex_r, ey: ey_r};

  assign ce        = !skid_vld_r;
  assign in_tready = ce;

  als_front #(.CB(CB), .SB(SB)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_vld (in_tvalid),
    .pt_x   ($signed(in_tdata[CB-1:0])),
    .pt_y   ($signed(in_tdata[2*CB-1:CB])),
    .pt_z   ($signed(in_tdata[3*CB-1:2*CB])),
    .smp_u  (in_tdata[3*CB +: SB]),
    .smp_v  (in_tdata[3*CB+SB +: SB]),
    .geom   (geom),
    .vld    (f_vld),
    .sq     (f_sq),
    .absdot (f_ad),
    .neg    (f_neg),
    .mag    (f_mag),
    .dneg   (f_dneg)
  );

  als_sqrt #(.XW(XW), .PLW(PLS)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (f_vld),
    .x       ({f_sq, 12'd0}),
    .pay_in  ({f_sq, f_ad, f_neg, f_mag, f_dneg}),
    .vld     (s_vld),
    .root    (s_root),
    .pay_out (s_pay)
  );

  assign {s_sq, s_ad, s_neg, s_mag, s_dneg} = s_pay;

  assign dsum     = (RW+1)'(s_root) + (RW+1)'(DIST_ROUND);
  assign dshr     = dsum >> DIST_SHIFT;
  assign dist_nxt = (dshr > (RW+1)'(DIST_MAX)) ? DIST_MAX : dshr[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (ce) begin
      m1_vld_r <= s_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ph_r    <= s_sq[SQW-1:SL] * s_root;
      pl_r    <= s_sq[SL-1:0] * s_root;
      ah_r    <= area_r * s_ad[AW-1:AL];
      al_r    <= area_r * s_ad[AL-1:0];
      for (int k = 0; k < 3; k++) begin
        nd1_r[k] <= (NDW'(s_mag[k]) << DIR_SHIFT) + NDW'(s_root);
      end
      dd1_r   <= {s_root, 1'b0};
      dn1_r   <= s_dneg;
      zero1_r <= (s_sq == '0);
      cosz1_r <= (s_ad == '0);
      neg1_r  <= s_neg;
      dist1_r <= dist_nxt;

      num2_r  <= ((NUMW'(ph_r) << SL) + NUMW'(pl_r)) << PDF_SHIFT;
      den2_r  <= (DENW'(ah_r) << AL) + DENW'(al_r);
      nd2_r   <= nd1_r;
      dd2_r   <= dd1_r;
      dn2_r   <= dn1_r;
      zero2_r <= zero1_r;
      cosz2_r <= cosz1_r;
      neg2_r  <= neg1_r;
      dist2_r <= dist1_r;

      sat3_r  <= SATW'(num2_r) >= (SATW'(den2_r) << PDF_W);
      num3_r  <= num2_r;
      den3_r  <= den2_r;
      nd3_r   <= nd2_r;
      dd3_r   <= dd2_r;
      dn3_r   <= dn2_r;
      zero3_r <= zero2_r;
      cosz3_r <= cosz2_r;
      neg3_r  <= neg2_r;
      dist3_r <= dist2_r;
    end
  end

  als_div #(.NW(NUMW), .DNW(DENW), .QW(PDF_W), .PLW(PLP)) u_div_pdf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (m3_vld_r),
    .num     (num3_r),
    .den     (den3_r),
    .pay_in  ({zero3_r, cosz3_r, neg3_r, sat3_r, dist3_r}),
    .vld     (p_vld),
    .quo     (p_quo),
    .pay_out (p_pay)
  );

  assign {p_zero, p_cosz, p_neg, p_sat, p_dist} = p_pay;

  for (genvar k = 0; k < 3; k++) begin : g_dir
    als_div #(.NW(NDW), .DNW(DDW), .QW(PDF_W), .PLW(1)) u_div_dir (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .in_vld  (m3_vld_r),
      .num     (nd3_r[k]),
      .den     (dd3_r),
      .pay_in  (dn3_r[k]),
      .vld     (q_vld[k]),
      .quo     (q_quo[k]),
      .pay_out (q_neg[k])
    );
  end

  assign push  = p_vld && (&q_vld) && ce;
  assign area0 = (area_r == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = (q_quo[k] > PDF_W'(DIR_ONE)) ? DIR_ONE : q_quo[k][DIR_W-1:0];
      if (p_zero) begin
        dval[k] = '0;
      end else begin
        dval[k] = q_neg[k] ? DIR_W'(-dmag[k]) : dmag[k];
      end
    end
    facing   = !p_zero && p_neg && !p_cosz;
    degen    = p_zero || p_cosz || area0;
    pdf_val  = (degen || p_sat) ? PDF_MAX : p_quo;
    dist_val = p_zero ? '0 : p_dist;
    rad_val  = facing ? rad_r : '0;
    res_nxt  = '0;
    res_nxt[OUT_DX_LSB +: DIR_W]    = dval[0];
    res_nxt[OUT_DY_LSB +: DIR_W]    = dval[1];
    res_nxt[OUT_DZ_LSB +: DIR_W]    = dval[2];
    res_nxt[OUT_DIST_LSB +: DIST_W] = dist_val;
    res_nxt[OUT_PDF_LSB +: PDF_W]   = pdf_val;
    res_nxt[OUT_RED_LSB +: RAD_W]   = rad_val;
    res_nxt[OUT_TDATA_W + TU_FACING] = facing;
    res_nxt[OUT_TDATA_W + TU_DEGEN]  = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_tready) begin
      if (push) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (push) begin
        skid_data_r <= res_nxt;
      end
    end else if (skid_vld_r) begin
      out_data_r <= skid_data_r;
    end else if (push) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r[OUT_TDATA_W-1:0];
  assign out_tuser  = out_data_r[RESW-1:OUT_TDATA_W];

endmodule
`default_nettype wire

/* rtl/core/als_checker.sv */
`default_nettype none
module als_checker import als_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[TU_FACING] |-> out_tdata[OUT_RED_LSB +: 3*CH_W] == '0)
    else $error("radiance without facing");

  a_degen_pdf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_DEGEN] |-> out_tdata[OUT_PDF_LSB +: PDF_W] == PDF_MAX)
    else $error("degenerate pdf not saturated");

  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DIST_LSB +: DIST_W] == '0 |->
      out_tuser[TU_DEGEN] && !out_tuser[TU_FACING] && out_tdata[OUT_DIST_LSB-1:0] == '0)
    else $error("zero distance result malformed");

endmodule

bind area_light_sample als_checker u_als_checker (.*);
`default_nettype wire
